// ----- design/aie_pkg.sv -----
// ----------------------------------------------------------------------------
// aie_pkg
// Shared types, field codes and helpers for the accumulator instruction
// executor.
// ----------------------------------------------------------------------------
package aie_pkg;

    localparam int WORD_W     = 16;
    localparam int ADDR_W     = 8;
    localparam int PAGE_WORDS = 256;
    localparam int NUM_AC     = 4;
    localparam int DISP_W     = 8;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef t_word [NUM_AC-1:0] t_acs;

    // item operation
    localparam logic OP_EXEC  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // memory-reference groups
    localparam logic [1:0] GRP_JUMP = 2'd0;
    localparam logic [1:0] GRP_LDA  = 2'd1;
    localparam logic [1:0] GRP_STA  = 2'd2;
    localparam logic [1:0] GRP_NONE = 2'd3;

    // jump group functions
    localparam logic [1:0] SEL_JMP = 2'd0;
    localparam logic [1:0] SEL_JSR = 2'd1;
    localparam logic [1:0] SEL_ISZ = 2'd2;
    localparam logic [1:0] SEL_DSZ = 2'd3;

    // addressing modes
    localparam logic [1:0] IDX_PAGE0 = 2'd0;
    localparam logic [1:0] IDX_PC    = 2'd1;
    localparam logic [1:0] IDX_AC2   = 2'd2;
    localparam logic [1:0] IDX_AC3   = 2'd3;

    localparam logic [1:0] AC_THREE = 2'd3;

    // alc functions
    localparam logic [2:0] FN_COM = 3'd0;
    localparam logic [2:0] FN_NEG = 3'd1;
    localparam logic [2:0] FN_MOV = 3'd2;
    localparam logic [2:0] FN_INC = 3'd3;
    localparam logic [2:0] FN_ADC = 3'd4;
    localparam logic [2:0] FN_SUB = 3'd5;
    localparam logic [2:0] FN_ADD = 3'd6;
    localparam logic [2:0] FN_AND = 3'd7;

    // alc shifts
    localparam logic [1:0] SH_NONE = 2'd0;
    localparam logic [1:0] SH_ROL  = 2'd1;
    localparam logic [1:0] SH_ROR  = 2'd2;
    localparam logic [1:0] SH_SWAP = 2'd3;

    // alc carry control
    localparam logic [1:0] CY_KEEP = 2'd0;
    localparam logic [1:0] CY_ZERO = 2'd1;
    localparam logic [1:0] CY_ONE  = 2'd2;
    localparam logic [1:0] CY_COMP = 2'd3;

    typedef struct packed {
        logic  operation;
        t_word instruction;
        t_word pc;
        t_acs  acs;
        logic  carry;
        t_addr load_address;
        t_word load_data;
    } t_item;

    typedef struct packed {
        t_acs  acs;
        logic  carry;
        logic  skip;
        logic  mem_written;
        t_addr wr_addr;
        t_word wr_value;
        logic  jump;
        t_word jump_addr;
        logic  supported;
    } t_result;

    typedef struct packed {
        t_word      value;
        logic       carry;
        logic       skip;
        logic       load;
        logic [1:0] dest;
    } t_alc_res;

    function automatic t_word ext_disp(input logic [DISP_W-1:0] d);
        return {{(WORD_W-DISP_W){d[DISP_W-1]}}, d};
    endfunction

endpackage

// ----- design/accumulator_instruction_executor.sv -----
// ----------------------------------------------------------------------------
// accumulator_instruction_executor
// Executes one instruction of a four-accumulator machine against a 256-word
// page-zero store held in the block. Three pipeline stages share the store:
// at acceptance the effective address is formed and the indirect word is
// read, the next stage resolves the indirect address and reads the operand,
// the last stage executes (alc or memory reference) and writes the store,
// then the result sits in an output register. A new transaction is taken
// every cycle while the input is not stalled. The store has one write and
// two read ports, and words in flight are forwarded from the pending and the
// last write. Reset clears a valid bit per word at once, so the store reads
// as zero without a clearing pass. The input stalls only when a result is
// held at a stalled output and the execute stage is occupied.
// ----------------------------------------------------------------------------
module accumulator_instruction_executor import aie_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [15:0] i_instruction,
    input  logic [15:0] i_program_counter,
    input  logic [15:0] i_acc_zero_in,
    input  logic [15:0] i_acc_one_in,
    input  logic [15:0] i_acc_two_in,
    input  logic [15:0] i_acc_three_in,
    input  logic        i_carry_in,
    input  logic [7:0]  i_load_address,
    input  logic [15:0] i_load_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_acc_zero_out,
    output logic [15:0] o_acc_one_out,
    output logic [15:0] o_acc_two_out,
    output logic [15:0] o_acc_three_out,
    output logic        o_carry_out,
    output logic        o_skip_next,
    output logic        o_memory_written,
    output logic [7:0]  o_written_address,
    output logic [15:0] o_written_value,
    output logic        o_takes_jump,
    output logic [15:0] o_jump_address,
    output logic        o_supported
);

    logic     adv;
    t_item    in_item;
    t_word    ea0;
    t_word    disp_ext;

    logic     r_s1_valid;
    t_item    r_s1;
    t_word    r_s1_ea;
    logic     r_s2_valid;
    t_item    r_s2;
    t_word    r_s2_ea;
    logic     r_lw_valid;
    t_addr    r_lw_addr;
    t_word    r_lw_data;
    logic     r_o_valid;
    logic     n_o_valid;
    t_result  r_out;

    t_word    rd_a_data;
    t_word    rd_b_data;
    t_word    ptr;
    t_word    s1_ea;
    t_word    operand;
    t_word    incdec;
    t_addr    e2;
    logic     s2_wr_raw;
    logic     s2_wr;
    t_addr    s2_waddr;
    t_word    s2_wdata;
    t_result  n_res;
    t_alc_res alc;

    assign adv     = ~(r_o_valid & i_stall & r_s2_valid);
    assign o_stall = ~adv;

    assign in_item.operation    = i_operation;
    assign in_item.instruction  = i_instruction;
    assign in_item.pc           = i_program_counter;
    assign in_item.acs          = {i_acc_three_in, i_acc_two_in, i_acc_one_in, i_acc_zero_in};
    assign in_item.carry        = i_carry_in;
    assign in_item.load_address = i_load_address;
    assign in_item.load_data    = i_load_data;

    // effective address before indirection
    assign disp_ext = ext_disp(i_instruction[DISP_W-1:0]);

    always_comb begin
        case (i_instruction[9:8])
            IDX_PAGE0: ea0 = {{(WORD_W-DISP_W){1'b0}}, i_instruction[DISP_W-1:0]};
            IDX_PC:    ea0 = t_word'(i_program_counter + disp_ext);
            IDX_AC2:   ea0 = t_word'(i_acc_two_in + disp_ext);
            default:   ea0 = t_word'(i_acc_three_in + disp_ext);
        endcase
    end

    aie_mem u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (adv),
        .i_rd_a_addr (ea0[ADDR_W-1:0]),
        .i_rd_b_addr (s1_ea[ADDR_W-1:0]),
        .i_wr_en     (s2_wr & adv),
        .i_wr_addr   (s2_waddr),
        .i_wr_data   (s2_wdata),
        .o_rd_a_data (rd_a_data),
        .o_rd_b_data (rd_b_data)
    );

    // indirect word with forwarding from pending and last write
    always_comb begin
        if (s2_wr && s2_waddr == r_s1_ea[ADDR_W-1:0]) begin
            ptr = s2_wdata;
        end else if (r_lw_valid && r_lw_addr == r_s1_ea[ADDR_W-1:0]) begin
            ptr = r_lw_data;
        end else begin
            ptr = rd_a_data;
        end
        s1_ea = r_s1.instruction[10] ? ptr : r_s1_ea;
    end

    aie_alc u_alc (
        .i_instruction (r_s2.instruction),
        .i_acs         (r_s2.acs),
        .i_carry       (r_s2.carry),
        .o_res         (alc)
    );

    // execute stage
    always_comb begin
        e2 = r_s2_ea[ADDR_W-1:0];
        if (r_lw_valid && r_lw_addr == e2) begin
            operand = r_lw_data;
        end else begin
            operand = rd_b_data;
        end
        incdec = (r_s2.instruction[12:11] == SEL_ISZ) ? t_word'(operand + t_word'(1))
                                                      : t_word'(operand - t_word'(1));

        n_res.acs         = r_s2.acs;
        n_res.carry       = r_s2.carry;
        n_res.skip        = 1'b0;
        n_res.mem_written = 1'b0;
        n_res.wr_addr     = '0;
        n_res.wr_value    = '0;
        n_res.jump        = 1'b0;
        n_res.jump_addr   = '0;
        n_res.supported   = 1'b1;
        s2_wr_raw         = 1'b0;
        s2_waddr          = r_s2.load_address;
        s2_wdata          = r_s2.load_data;

        if (r_s2.operation == OP_WRITE) begin
            s2_wr_raw = 1'b1;
        end else if (r_s2.instruction[15]) begin
            n_res.skip = alc.skip;
            if (alc.load) begin
                n_res.acs[alc.dest] = alc.value;
                n_res.carry         = alc.carry;
            end
        end else begin
            case (r_s2.instruction[14:13])
                GRP_LDA: n_res.acs[r_s2.instruction[12:11]] = operand;
                GRP_STA: begin
                    s2_wr_raw         = 1'b1;
                    s2_waddr          = e2;
                    s2_wdata          = r_s2.acs[r_s2.instruction[12:11]];
                    n_res.mem_written = 1'b1;
                    n_res.wr_addr     = e2;
                    n_res.wr_value    = s2_wdata;
                end
                GRP_JUMP: begin
                    case (r_s2.instruction[12:11])
                        SEL_JMP: begin
                            n_res.jump      = 1'b1;
                            n_res.jump_addr = r_s2_ea;
                        end
                        SEL_JSR: begin
                            n_res.acs[AC_THREE] = t_word'(r_s2.pc + t_word'(1));
                            n_res.jump          = 1'b1;
                            n_res.jump_addr     = r_s2_ea;
                        end
                        default: begin
                            s2_wr_raw         = 1'b1;
                            s2_waddr          = e2;
                            s2_wdata          = incdec;
                            n_res.mem_written = 1'b1;
                            n_res.wr_addr     = e2;
                            n_res.wr_value    = incdec;
                            n_res.skip        = (incdec == '0);
                        end
                    endcase
                end
                default: n_res.supported = 1'b0;
            endcase
        end
    end

    assign s2_wr = r_s2_valid & s2_wr_raw;

    assign n_o_valid = (adv & r_s2_valid) | (r_o_valid & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_lw_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
            if (adv) begin
                r_s1_valid <= i_valid;
                r_s2_valid <= r_s1_valid;
                r_lw_valid <= s2_wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1      <= in_item;
            r_s1_ea   <= ea0;
            r_s2      <= r_s1;
            r_s2_ea   <= s1_ea;
            r_lw_addr <= s2_waddr;
            r_lw_data <= s2_wdata;
        end
        if (adv && r_s2_valid) begin
            r_out <= n_res;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_acc_zero_out    = r_out.acs[0];
    assign o_acc_one_out     = r_out.acs[1];
    assign o_acc_two_out     = r_out.acs[2];
    assign o_acc_three_out   = r_out.acs[3];
    assign o_carry_out       = r_out.carry;
    assign o_skip_next       = r_out.skip;
    assign o_memory_written  = r_out.mem_written;
    assign o_written_address = r_out.wr_addr;
    assign o_written_value   = r_out.wr_value;
    assign o_takes_jump      = r_out.jump;
    assign o_jump_address    = r_out.jump_addr;
    assign o_supported       = r_out.supported;

endmodule

// ----- design/aie_mem.sv -----
// ----------------------------------------------------------------------------
// aie_mem
// Page-zero store: one write port, two registered read ports, and a valid
// bit per word so unwritten words read as zero right after reset.
// ----------------------------------------------------------------------------
module aie_mem import aie_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_rd_en,
    input  t_addr i_rd_a_addr,
    input  t_addr i_rd_b_addr,
    input  logic  i_wr_en,
    input  t_addr i_wr_addr,
    input  t_word i_wr_data,
    output t_word o_rd_a_data,
    output t_word o_rd_b_data
);

    t_word                 r_mem [PAGE_WORDS];
    logic [PAGE_WORDS-1:0] r_vld;
    t_word                 r_rd_a;
    t_word                 r_rd_b;
    logic                  r_rd_a_vld;
    logic                  r_rd_b_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_a_addr];
            r_rd_b <= r_mem[i_rd_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_a_vld <= 1'b0;
            r_rd_b_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_a_vld <= r_vld[i_rd_a_addr];
            r_rd_b_vld <= r_vld[i_rd_b_addr];
        end
    end

    assign o_rd_a_data = r_rd_a_vld ? r_rd_a : '0;
    assign o_rd_b_data = r_rd_b_vld ? r_rd_b : '0;

endmodule

// ----- design/aie_alc.sv -----
// ----------------------------------------------------------------------------
// aie_alc
// Arithmetic/logic class datapath: function unit, carry generator,
// rotate/swap shifter and skip sensor.
// ----------------------------------------------------------------------------
module aie_alc import aie_pkg::*; (
    input  t_word    i_instruction,
    input  t_acs     i_acs,
    input  logic     i_carry,
    output t_alc_res o_res
);

    localparam int HALF_W = WORD_W / 2;

    t_word         src;
    t_word         dst;
    logic          cin;
    logic          ov;
    logic          cr;
    t_word         res;
    t_word         sr;
    logic          sc;
    logic [WORD_W:0] sum;

    always_comb begin
        src = i_acs[i_instruction[14:13]];
        dst = i_acs[i_instruction[12:11]];

        case (i_instruction[5:4])
            CY_KEEP: cin = i_carry;
            CY_ZERO: cin = 1'b0;
            CY_ONE:  cin = 1'b1;
            default: cin = ~i_carry;
        endcase

        sum = '0;
        ov  = 1'b0;
        case (i_instruction[10:8])
            FN_COM: res = ~src;
            FN_NEG: begin
                res = t_word'(~src + t_word'(1));
                ov  = (src == '0);
            end
            FN_MOV: res = src;
            FN_INC: begin
                res = t_word'(src + t_word'(1));
                ov  = &src;
            end
            FN_ADC: begin
                sum = {1'b0, dst} + {1'b0, ~src};
                res = sum[WORD_W-1:0];
                ov  = sum[WORD_W];
            end
            FN_SUB: begin
                sum = {1'b0, dst} + {1'b0, ~src} + {{WORD_W{1'b0}}, 1'b1};
                res = sum[WORD_W-1:0];
                ov  = sum[WORD_W];
            end
            FN_ADD: begin
                sum = {1'b0, dst} + {1'b0, src};
                res = sum[WORD_W-1:0];
                ov  = sum[WORD_W];
            end
            default: res = dst & src;
        endcase

        cr = cin ^ ov;

        case (i_instruction[7:6])
            SH_ROL: begin
                sr = {res[WORD_W-2:0], cr};
                sc = res[WORD_W-1];
            end
            SH_ROR: begin
                sr = {cr, res[WORD_W-1:1]};
                sc = res[0];
            end
            SH_SWAP: begin
                sr = {res[HALF_W-1:0], res[WORD_W-1:HALF_W]};
                sc = cr;
            end
            default: begin
                sr = res;
                sc = cr;
            end
        endcase

        o_res.value = sr;
        o_res.carry = sc;
        o_res.skip  = ((~sc & i_instruction[1]) | ((sr == '0) & i_instruction[2]))
                      ^ i_instruction[0];
        o_res.load  = ~i_instruction[3];
        o_res.dest  = i_instruction[12:11];
    end

endmodule

// ----- design/aie_checker.sv -----
// ----------------------------------------------------------------------------
// aie_checker
// Port-level checks for the accumulator instruction executor, bound to the
// top level.
// ----------------------------------------------------------------------------
module aie_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_acc_zero_out,
    input logic [15:0] o_acc_one_out,
    input logic [15:0] o_acc_two_out,
    input logic [15:0] o_acc_three_out,
    input logic        o_carry_out,
    input logic        o_skip_next,
    input logic        o_memory_written,
    input logic [7:0]  o_written_address,
    input logic [15:0] o_written_value,
    input logic        o_takes_jump,
    input logic [15:0] o_jump_address,
    input logic        o_supported
);

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output transaction valid after reset");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("stalled output transaction dropped");

    a_stall_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable({o_acc_zero_out, o_acc_one_out, o_acc_two_out,
                                        o_acc_three_out, o_carry_out, o_skip_next,
                                        o_memory_written, o_written_address,
                                        o_written_value, o_takes_jump, o_jump_address,
                                        o_supported}))
        else $error("stalled output transaction changed");

    a_no_store_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_memory_written |-> o_written_address == 8'd0 && o_written_value == 16'd0)
        else $error("store fields set without a store");

    a_unsupported_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_supported |-> !o_skip_next && !o_memory_written && !o_takes_jump
                                    && o_jump_address == 16'd0)
        else $error("unsupported instruction has side effects");

endmodule

bind accumulator_instruction_executor aie_checker u_aie_checker (.*);

// ----- sim/tb_accumulator_instruction_executor.sv -----
// ----------------------------------------------------------------------------
// tb_accumulator_instruction_executor
// Self-checking testbench for the accumulator instruction executor. A short
// directed sequence exercises every alc function, shift, carry control and
// skip condition, each memory-reference form and the page store boundaries.
// A long random run of execute and store-write transactions follows. Every
// accepted transaction is run through a predictor with its own copy of the
// page store, and each returned result is compared field by field in order.
// Sender bursts and receiver stalls are random, with one long receiver
// hold-off that backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_accumulator_instruction_executor import aie_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1080;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 12;
    localparam int REPORT_LIMIT = 10;

    localparam logic [1:0] AC_ZERO = 2'd0;
    localparam logic [1:0] AC_ONE  = 2'd1;
    localparam logic [1:0] AC_TWO  = 2'd2;

    // alc skip field: bit 2 zero result, bit 1 carry zero, bit 0 invert
    localparam logic [2:0] SKP_NEVER  = 3'd0;
    localparam logic [2:0] SKP_ALWAYS = 3'd1;
    localparam logic [2:0] SKP_SZC    = 3'd2;
    localparam logic [2:0] SKP_SNC    = 3'd3;
    localparam logic [2:0] SKP_SZR    = 3'd4;
    localparam logic [2:0] SKP_SNR    = 3'd5;
    localparam logic [2:0] SKP_SEZ    = 3'd6;
    localparam logic [2:0] SKP_SBN    = 3'd7;

    class outcome_board;
        t_word       page_store [PAGE_WORDS];
        t_result     pending_outcomes [$];
        int unsigned instructions_noted;
        int unsigned outcomes_checked;
        int unsigned mismatch_count;

        function new();
            foreach (page_store[w]) page_store[w] = '0;
            instructions_noted = 0;
            outcomes_checked   = 0;
            mismatch_count     = 0;
        endfunction

        function t_result execute_instruction(input t_item it);
            t_result     r;
            t_word       op, src, dst, alu, shifted, ea, v;
            logic [16:0] sum;
            logic        cin, ovf, cry, shc;
            logic [1:0]  grp, sel;
            logic [7:0]  e;
            op          = it.instruction;
            r           = '0;
            r.acs       = it.acs;
            r.carry     = it.carry;
            r.supported = 1'b1;
            if (it.operation == OP_WRITE) begin
                page_store[it.load_address] = it.load_data;
            end else if (op[15]) begin
                src = it.acs[op[14:13]];
                dst = it.acs[op[12:11]];
                case (op[5:4])
                    CY_KEEP: cin = it.carry;
                    CY_ZERO: cin = 1'b0;
                    CY_ONE:  cin = 1'b1;
                    default: cin = ~it.carry;
                endcase
                ovf = 1'b0;
                case (op[10:8])
                    FN_COM: alu = ~src;
                    FN_NEG: begin
                        alu = -src;
                        ovf = (src == '0);
                    end
                    FN_MOV: alu = src;
                    FN_INC: begin
                        alu = src + 16'd1;
                        ovf = (src == 16'hFFFF);
                    end
                    FN_ADC: begin
                        sum = {1'b0, dst} + {1'b0, ~src};
                        alu = sum[15:0];
                        ovf = sum[16];
                    end
                    FN_SUB: begin
                        sum = {1'b0, dst} + {1'b0, ~src} + 17'd1;
                        alu = sum[15:0];
                        ovf = sum[16];
                    end
                    FN_ADD: begin
                        sum = {1'b0, dst} + {1'b0, src};
                        alu = sum[15:0];
                        ovf = sum[16];
                    end
                    default: alu = dst & src;
                endcase
                cry = cin ^ ovf;
                case (op[7:6])
                    SH_ROL: begin
                        shifted = {alu[14:0], cry};
                        shc     = alu[15];
                    end
                    SH_ROR: begin
                        shifted = {cry, alu[15:1]};
                        shc     = alu[0];
                    end
                    SH_SWAP: begin
                        shifted = {alu[7:0], alu[15:8]};
                        shc     = cry;
                    end
                    default: begin
                        shifted = alu;
                        shc     = cry;
                    end
                endcase
                r.skip = (((shc == 1'b0) & op[1]) | ((shifted == '0) & op[2])) ^ op[0];
                if (!op[3]) begin
                    r.acs[op[12:11]] = shifted;
                    r.carry          = shc;
                end
            end else begin
                grp = op[14:13];
                sel = op[12:11];
                if (grp == GRP_NONE) begin
                    r.supported = 1'b0;
                end else begin
                    case (op[9:8])
                        IDX_PAGE0: ea = {8'h00, op[7:0]};
                        IDX_PC:    ea = it.pc + {{8{op[7]}}, op[7:0]};
                        IDX_AC2:   ea = it.acs[AC_TWO] + {{8{op[7]}}, op[7:0]};
                        default:   ea = it.acs[AC_THREE] + {{8{op[7]}}, op[7:0]};
                    endcase
                    if (op[10]) ea = page_store[ea[7:0]];
                    e = ea[7:0];
                    case (grp)
                        GRP_LDA: r.acs[sel] = page_store[e];
                        GRP_STA: begin
                            page_store[e] = it.acs[sel];
                            r.mem_written = 1'b1;
                            r.wr_addr     = e;
                            r.wr_value    = it.acs[sel];
                        end
                        default: begin
                            case (sel)
                                SEL_JMP: begin
                                    r.jump      = 1'b1;
                                    r.jump_addr = ea;
                                end
                                SEL_JSR: begin
                                    r.acs[AC_THREE] = it.pc + 16'd1;
                                    r.jump          = 1'b1;
                                    r.jump_addr     = ea;
                                end
                                default: begin
                                    v = (sel == SEL_ISZ) ? page_store[e] + 16'd1
                                                         : page_store[e] - 16'd1;
                                    page_store[e] = v;
                                    r.mem_written = 1'b1;
                                    r.wr_addr     = e;
                                    r.wr_value    = v;
                                    r.skip        = (v == '0);
                                end
                            endcase
                        end
                    endcase
                end
            end
            return r;
        endfunction

        function void note_instruction(input t_item it);
            pending_outcomes.push_back(execute_instruction(it));
            instructions_noted++;
        endfunction

        function void compare_field(input string name, input int unsigned want,
                                    input int unsigned got);
            if (want != got) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("mismatch in result %0d, %s: expected 0x%0h, got 0x%0h",
                             outcomes_checked, name, want, got);
                end
            end
        endfunction

        function void check_outcome(input t_result got);
            t_result want;
            int      a;
            outcomes_checked++;
            if (pending_outcomes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("result %0d arrived with no transaction pending",
                             outcomes_checked);
                end
                return;
            end
            want = pending_outcomes.pop_front();
            for (a = 0; a < NUM_AC; a++) begin
                compare_field($sformatf("acc%0d", a), want.acs[a], got.acs[a]);
            end
            compare_field("carry", want.carry, got.carry);
            compare_field("skip", want.skip, got.skip);
            compare_field("memory_written", want.mem_written, got.mem_written);
            compare_field("written_address", want.wr_addr, got.wr_addr);
            compare_field("written_value", want.wr_value, got.wr_value);
            compare_field("takes_jump", want.jump, got.jump);
            compare_field("jump_address", want.jump_addr, got.jump_addr);
            compare_field("supported", want.supported, got.supported);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_operation;
    logic [15:0] i_instruction;
    logic [15:0] i_program_counter;
    logic [15:0] i_acc_zero_in;
    logic [15:0] i_acc_one_in;
    logic [15:0] i_acc_two_in;
    logic [15:0] i_acc_three_in;
    logic        i_carry_in;
    logic [7:0]  i_load_address;
    logic [15:0] i_load_data;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_acc_zero_out;
    logic [15:0] o_acc_one_out;
    logic [15:0] o_acc_two_out;
    logic [15:0] o_acc_three_out;
    logic        o_carry_out;
    logic        o_skip_next;
    logic        o_memory_written;
    logic [7:0]  o_written_address;
    logic [15:0] o_written_value;
    logic        o_takes_jump;
    logic [15:0] o_jump_address;
    logic        o_supported;

    outcome_board board;
    t_item        taken_item;
    t_result      taken_result;

    accumulator_instruction_executor u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_instruction     (i_instruction),
        .i_program_counter (i_program_counter),
        .i_acc_zero_in     (i_acc_zero_in),
        .i_acc_one_in      (i_acc_one_in),
        .i_acc_two_in      (i_acc_two_in),
        .i_acc_three_in    (i_acc_three_in),
        .i_carry_in        (i_carry_in),
        .i_load_address    (i_load_address),
        .i_load_data       (i_load_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_acc_zero_out    (o_acc_zero_out),
        .o_acc_one_out     (o_acc_one_out),
        .o_acc_two_out     (o_acc_two_out),
        .o_acc_three_out   (o_acc_three_out),
        .o_carry_out       (o_carry_out),
        .o_skip_next       (o_skip_next),
        .o_memory_written  (o_memory_written),
        .o_written_address (o_written_address),
        .o_written_value   (o_written_value),
        .o_takes_jump      (o_takes_jump),
        .o_jump_address    (o_jump_address),
        .o_supported       (o_supported)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_word alc_word(input logic [1:0] src, input logic [1:0] dst,
                                       input logic [2:0] fn, input logic [1:0] sh,
                                       input logic [1:0] cy, input logic nl,
                                       input logic [2:0] skp);
        return {1'b1, src, dst, fn, sh, cy, nl, skp};
    endfunction

    function automatic t_word mref_word(input logic [1:0] grp, input logic [1:0] sel,
                                        input logic ind, input logic [1:0] idx,
                                        input logic [7:0] disp);
        return {1'b0, grp, sel, ind, idx, disp};
    endfunction

    function automatic t_item exec_item(input t_word instr, input t_word pc,
                                        input t_word a0, input t_word a1,
                                        input t_word a2, input t_word a3,
                                        input logic c);
        t_item it;
        it              = '0;
        it.operation    = OP_EXEC;
        it.instruction  = instr;
        it.pc           = pc;
        it.acs[AC_ZERO] = a0;
        it.acs[AC_ONE]  = a1;
        it.acs[AC_TWO]  = a2;
        it.acs[AC_THREE] = a3;
        it.carry        = c;
        return it;
    endfunction

    function automatic t_item write_item(input t_addr addr, input t_word data);
        t_item it;
        it              = '0;
        it.operation    = OP_WRITE;
        it.load_address = addr;
        it.load_data    = data;
        return it;
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return t_word'($urandom_range(0, 3));
            default: return t_word'($urandom());
        endcase
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    kind;
        int    a;
        it.operation    = OP_EXEC;
        it.instruction  = t_word'($urandom());
        it.pc           = t_word'($urandom());
        for (a = 0; a < NUM_AC; a++) it.acs[a] = pick_word();
        it.carry        = 1'($urandom_range(0, 1));
        it.load_address = t_addr'($urandom());
        it.load_data    = pick_word();
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            it.operation = OP_WRITE;
            if ($urandom_range(0, 1)) it.load_address = t_addr'($urandom_range(0, 15));
        end else if (kind < 52) begin
            it.instruction[15] = 1'b1;
        end else begin
            it.instruction[15]    = 1'b0;
            it.instruction[14:13] = (kind < 97) ? 2'($urandom_range(0, 2)) : GRP_NONE;
            if ($urandom_range(0, 1)) begin
                it.instruction[9:8] = IDX_PAGE0;
                it.instruction[7:0] = 8'($urandom_range(0, 15));
            end
        end
        return it;
    endfunction

    task automatic send_item(input t_item it);
        i_valid           <= 1'b1;
        i_operation       <= it.operation;
        i_instruction     <= it.instruction;
        i_program_counter <= it.pc;
        i_acc_zero_in     <= it.acs[AC_ZERO];
        i_acc_one_in      <= it.acs[AC_ONE];
        i_acc_two_in      <= it.acs[AC_TWO];
        i_acc_three_in    <= it.acs[AC_THREE];
        i_carry_in        <= it.carry;
        i_load_address    <= it.load_address;
        i_load_data       <= it.load_data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // transaction monitor: inputs are predicted before results are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                taken_item.operation    = i_operation;
                taken_item.instruction  = i_instruction;
                taken_item.pc           = i_program_counter;
                taken_item.acs[AC_ZERO] = i_acc_zero_in;
                taken_item.acs[AC_ONE]  = i_acc_one_in;
                taken_item.acs[AC_TWO]  = i_acc_two_in;
                taken_item.acs[AC_THREE] = i_acc_three_in;
                taken_item.carry        = i_carry_in;
                taken_item.load_address = i_load_address;
                taken_item.load_data    = i_load_data;
                board.note_instruction(taken_item);
            end
            if (o_valid && !i_stall) begin
                taken_result.acs[AC_ZERO]  = o_acc_zero_out;
                taken_result.acs[AC_ONE]   = o_acc_one_out;
                taken_result.acs[AC_TWO]   = o_acc_two_out;
                taken_result.acs[AC_THREE] = o_acc_three_out;
                taken_result.carry         = o_carry_out;
                taken_result.skip          = o_skip_next;
                taken_result.mem_written   = o_memory_written;
                taken_result.wr_addr       = o_written_address;
                taken_result.wr_value      = o_written_value;
                taken_result.jump          = o_takes_jump;
                taken_result.jump_addr     = o_jump_address;
                taken_result.supported     = o_supported;
                board.check_outcome(taken_result);
            end
        end
    end

    // receiver stall pattern with one long hold-off
    initial begin
        int   seg;
        int   pct;
        logic hold_done;
        hold_done = 1'b0;
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!hold_done && board.instructions_noted >= HOLD_AFTER) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            seg = $urandom_range(10, 80);
            case ($urandom_range(0, 3))
                0:       pct = 0;
                1:       pct = 25;
                2:       pct = 50;
                default: pct = 85;
            endcase
            repeat (seg) begin
                i_stall <= ($urandom_range(0, 99) < pct);
                @(posedge i_clk);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_item plan [$];
        int    sent;
        int    total;
        int    burst;
        int    gap;
        int    k;
        board = new();
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_operation       <= OP_EXEC;
        i_instruction     <= '0;
        i_program_counter <= '0;
        i_acc_zero_in     <= '0;
        i_acc_one_in      <= '0;
        i_acc_two_in      <= '0;
        i_acc_three_in    <= '0;
        i_carry_in        <= 1'b0;
        i_load_address    <= '0;
        i_load_data       <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // page store boundaries and words used below
        plan.push_back(write_item(8'hFF, 16'hFFFF));
        plan.push_back(write_item(8'h00, 16'h0001));
        plan.push_back(write_item(8'h01, 16'hFFFF));
        plan.push_back(write_item(8'h02, 16'h1234));
        plan.push_back(write_item(8'h34, 16'hBEEF));
        // alc functions, shifts, carry controls and skips
        plan.push_back(exec_item(alc_word(AC_ZERO, AC_ONE, FN_COM, SH_NONE, CY_KEEP, 1'b0,
                       SKP_SZR), 16'h0000, 16'hFFFF, 16'h0000, 16'h1111, 16'h2222, 1'b1));
        plan.push_back(exec_item(alc_word(AC_ONE, AC_TWO, FN_NEG, SH_ROL, CY_ZERO, 1'b0,
                       SKP_SNC), 16'h0010, 16'h1234, 16'h0000, 16'h5678, 16'h9ABC, 1'b1));
        plan.push_back(exec_item(alc_word(AC_TWO, AC_THREE, FN_MOV, SH_ROR, CY_ONE, 1'b0,
                       SKP_ALWAYS), 16'h0020, 16'h0000, 16'hFFFF, 16'h8001, 16'h0000, 1'b0));
        plan.push_back(exec_item(alc_word(AC_THREE, AC_ZERO, FN_INC, SH_SWAP, CY_COMP, 1'b0,
                       SKP_SEZ), 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0));
        plan.push_back(exec_item(alc_word(AC_ZERO, AC_ZERO, FN_ADC, SH_NONE, CY_KEEP, 1'b0,
                       SKP_SZC), 16'h0030, 16'h5555, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        plan.push_back(exec_item(alc_word(AC_ONE, AC_TWO, FN_SUB, SH_NONE, CY_ZERO, 1'b0,
                       SKP_SBN), 16'h0040, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1));
        plan.push_back(exec_item(alc_word(AC_TWO, AC_THREE, FN_ADD, SH_ROL, CY_ONE, 1'b0,
                       SKP_SNR), 16'h0050, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 1'b0));
        plan.push_back(exec_item(alc_word(AC_THREE, AC_ONE, FN_AND, SH_ROR, CY_COMP, 1'b1,
                       SKP_SEZ), 16'h0060, 16'h0000, 16'hF0F0, 16'h0000, 16'h0F0F, 1'b1));
        plan.push_back(exec_item(alc_word(AC_ZERO, AC_ONE, FN_AND, SH_NONE, CY_KEEP, 1'b0,
                       SKP_NEVER), 16'h0070, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0));
        // memory reference forms
        plan.push_back(exec_item(mref_word(GRP_LDA, AC_TWO, 1'b1, IDX_PAGE0, 8'h02),
                       16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        plan.push_back(exec_item(mref_word(GRP_STA, AC_ONE, 1'b0, IDX_AC2, 8'h80),
                       16'h0200, 16'h0000, 16'hA5A5, 16'h0190, 16'h0000, 1'b1));
        plan.push_back(exec_item(mref_word(GRP_STA, AC_ZERO, 1'b0, IDX_AC3, 8'h7F),
                       16'h0300, 16'h5A5A, 16'h0000, 16'h0000, 16'hFF90, 1'b0));
        plan.push_back(exec_item(mref_word(GRP_JUMP, SEL_JMP, 1'b1, IDX_PAGE0, 8'h02),
                       16'h0400, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        plan.push_back(exec_item(mref_word(GRP_JUMP, SEL_JSR, 1'b0, IDX_PC, 8'h01),
                       16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h1234, 1'b1));
        plan.push_back(exec_item(mref_word(GRP_JUMP, SEL_ISZ, 1'b0, IDX_PAGE0, 8'h01),
                       16'h0500, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        plan.push_back(exec_item(mref_word(GRP_JUMP, SEL_DSZ, 1'b0, IDX_PAGE0, 8'h00),
                       16'h0600, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        plan.push_back(exec_item(mref_word(GRP_JUMP, SEL_DSZ, 1'b0, IDX_PAGE0, 8'h00),
                       16'h0700, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        plan.push_back(exec_item(mref_word(GRP_NONE, SEL_DSZ, 1'b1, IDX_AC3, 8'hFF),
                       16'h0800, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 1'b1));
        plan.push_back(exec_item(mref_word(GRP_LDA, AC_THREE, 1'b0, IDX_PC, 8'hFF),
                       16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        plan.push_back(exec_item(mref_word(GRP_JUMP, SEL_ISZ, 1'b1, IDX_AC3, 8'h82),
                       16'h0900, 16'h0000, 16'h0000, 16'h0000, 16'h0080, 1'b0));
        plan.push_back(exec_item(mref_word(GRP_JUMP, SEL_JSR, 1'b1, IDX_AC2, 8'h7F),
                       16'h7FFF, 16'h0000, 16'h0000, 16'hFF83, 16'h0000, 1'b0));

        sent  = 0;
        total = plan.size() + RANDOM_ITEMS;
        while (sent < total) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
            for (k = 0; k < burst && sent < total; k++) begin
                send_item((sent < plan.size()) ? plan[sent] : random_item());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) pause_sender(gap);
        end
        i_valid <= 1'b0;

        while (board.pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
